### sv/qti_pkg.sv
// shared constants, types and codes of the quadrilinear table interpolator
`timescale 1ns / 1ps
`default_nettype none

package qti_pkg;

   // table geometry
   localparam int BINS        = 32;
   localparam int IDX_W       = $clog2(BINS);
   localparam int TABLE_DEPTH = BINS * BINS * BINS * BINS;
   localparam int TAB_AW      = $clog2(TABLE_DEPTH);
   localparam int AXES        = 4;
   localparam int CORNERS     = 16;

   // field widths
   localparam int COORD_W    = 32;
   localparam int ADDR_W     = 20;
   localparam int VALUE_W    = 32;
   localparam int REQ_DATA_W = 184;
   localparam int CSR_IDX_W  = 3;

   // weights are Q0.16 with one extra bit so that 1.0 fits
   localparam int WT_W = 17;
   localparam logic [WT_W-1:0] WT_ONE = WT_W'(65536);

   // commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_A  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_B  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_C  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_D  = 3'd7;

   // one job handed from the front end to the back end
   typedef struct packed {
      logic                          cmd;
      logic                          wr_ok;
      logic [TAB_AW-1:0]             addr;
      logic [VALUE_W-1:0]            value;
      logic [AXES-1:0][IDX_W-1:0]    idx;
      logic [AXES-1:0][WT_W-1:0]     wt;
   } qti_job_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_MUL,
      FE_MAP,
      FE_PUSH
   } qti_front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_WAIT,
      BK_FIN
   } qti_back_state_type;

endpackage

`default_nettype wire

### sv/qti_front.sv
// front end: takes requests, holds the registers, maps coordinates to indexes and weights
`timescale 1ns / 1ps
`default_nettype none

module qti_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [qti_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                            req_tuser,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [qti_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [qti_pkg::VALUE_W-1:0]     csr_data,
   output logic                                 push,
   output qti_pkg::qti_job_type                 push_job,
   input  wire logic                            q_full
);
   import qti_pkg::*;

   qti_front_state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;

   logic [AXES-1:0][COORD_W-1:0] origin_ff, scale_ff;
   logic [AXES-1:0][COORD_W-1:0] coord_ff;
   logic                         cmd_ff;
   logic [ADDR_W-1:0]            addr_ff;
   logic [VALUE_W-1:0]           value_ff;
   logic [AXES-1:0][IDX_W-1:0]   idx_ff;
   logic [AXES-1:0][WT_W-1:0]    wt_ff;
   logic [63:0]                  prod_ff, prod_in;
   logic                         neg_ff, neg_in;

   logic                         accept;
   logic                         map_we;
   logic [COORD_W:0]             diff;
   logic [COORD_W:0]             mag;
   logic [64:0]                  t_pos;
   logic [31:0]                  t_neg;
   logic [IDX_W-1:0]             map_idx;
   logic [WT_W-1:0]              map_wt;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < AXES; k++) begin
            origin_ff[k] <= '0;
            scale_ff[k]  <= COORD_W'(65536);
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_A: origin_ff[0] <= csr_data;
            CSR_ORIGIN_B: origin_ff[1] <= csr_data;
            CSR_ORIGIN_C: origin_ff[2] <= csr_data;
            CSR_ORIGIN_D: origin_ff[3] <= csr_data;
            CSR_SCALE_A:  scale_ff[0]  <= csr_data;
            CSR_SCALE_B:  scale_ff[1]  <= csr_data;
            CSR_SCALE_C:  scale_ff[2]  <= csr_data;
            CSR_SCALE_D:  scale_ff[3]  <= csr_data;
            default: ;
         endcase
      end
   end

   // exact (coord - origin) * scale in Q32.32, magnitude and sign kept apart
   always_comb begin
      diff    = {coord_ff[axis_ff][COORD_W-1], coord_ff[axis_ff]}
              - {origin_ff[axis_ff][COORD_W-1], origin_ff[axis_ff]};
      neg_in  = diff[COORD_W];
      mag     = neg_in ? ((COORD_W+1)'(0) - diff) : diff;
      prod_in = 64'(mag) * 64'(scale_ff[axis_ff]);
   end

   // add one half, then split into index and weight with clamping
   always_comb begin
      t_pos   = {1'b0, prod_ff} + 65'h0_8000_0000;
      t_neg   = 32'h8000_0000 - prod_ff[31:0];
      map_idx = '0;
      map_wt  = '0;
      if (neg_ff) begin
         if (prod_ff <= 64'h8000_0000) begin
            map_wt = {1'b0, t_neg[31:16]};
         end
      end else if (t_pos[64:32] > 33'(BINS - 1)) begin
         map_idx = IDX_W'(BINS - 1);
         map_wt  = WT_ONE;
      end else begin
         map_idx = t_pos[32 +: IDX_W];
         map_wt  = {1'b0, t_pos[31:16]};
      end
   end

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      req_tready = 1'b0;
      push       = 1'b0;
      map_we     = 1'b0;
      case (state_ff)
         FE_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               axis_in  = '0;
               state_in = (req_tuser == CMD_QUERY) ? FE_MUL : FE_PUSH;
            end
         end
         FE_MUL: begin
            state_in = FE_MAP;
         end
         FE_MAP: begin
            map_we = 1'b1;
            if (axis_ff == 2'(AXES - 1)) begin
               state_in = FE_PUSH;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = FE_MUL;
            end
         end
         FE_PUSH: begin
            if (!q_full) begin
               push     = 1'b1;
               state_in = FE_IDLE;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_tuser;
         coord_ff[0] <= req_tdata[31:0];
         coord_ff[1] <= req_tdata[63:32];
         coord_ff[2] <= req_tdata[95:64];
         coord_ff[3] <= req_tdata[127:96];
         addr_ff     <= req_tdata[147:128];
         value_ff    <= req_tdata[179:148];
      end
      if (state_ff == FE_MUL) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
      end
      if (map_we) begin
         idx_ff[axis_ff] <= map_idx;
         wt_ff[axis_ff]  <= map_wt;
      end
   end

   always_comb begin
      push_job.cmd   = cmd_ff;
      push_job.wr_ok = ({{(64-ADDR_W){1'b0}}, addr_ff} < 64'(TABLE_DEPTH));
      push_job.addr  = TAB_AW'(addr_ff);
      push_job.value = value_ff;
      push_job.idx   = idx_ff;
      push_job.wt    = wt_ff;
   end

endmodule

`default_nettype wire

### sv/qti_queue.sv
// two-entry job queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none

module qti_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  qti_pkg::qti_job_type       push_job,
   output logic                       full,
   output logic                       pop_valid,
   output qti_pkg::qti_job_type       pop_job,
   input  wire logic                  pop
);
   import qti_pkg::*;

   qti_job_type slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### sv/qti_back.sv
// back end: table memory, corner walk, weight pipeline, accumulation and result register
`timescale 1ns / 1ps
`default_nettype none

module qti_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   input  qti_pkg::qti_job_type               q_job,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [qti_pkg::VALUE_W-1:0]        rsp_tdata,
   output logic                               rsp_tuser
);
   import qti_pkg::*;

   localparam int ACC_W = 54;
   localparam int TERM_W = 50;
   localparam logic [3:0] LAST_CORNER = 4'(CORNERS - 1);
   localparam logic signed [ACC_W-17:0] Q_HI = (ACC_W-16)'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [ACC_W-17:0] Q_LO = (ACC_W-16)'(-64'sh0000_0000_8000_0000);

   qti_back_state_type state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   qti_job_type job_ff;

   logic [VALUE_W-1:0] mem [TABLE_DEPTH];

   logic                 job_ld, acc_clr, mem_we, issue, load_out, out_free;
   logic [VALUE_W-1:0]   out_value;
   logic                 out_cmd;

   logic [AXES-1:0][IDX_W-1:0] sel_idx;
   logic [AXES-1:0][WT_W-1:0]  sel_wt;
   logic [AXES-1:0]            corner_bit;
   logic [IDX_W-1:0]           lo;
   logic [TAB_AW-1:0]          rd_addr;

   // weight and data pipeline
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic               last1_ff, last2_ff, last3_ff, last4_ff;
   logic [VALUE_W-1:0] rd_data_ff, data2_ff, data3_ff;
   logic [WT_W-1:0]    wab_ff, wc1_ff, wd1_ff, wabc_ff, wd2_ff, w_ff;
   logic [33:0]        p_ab, p_abc, p_w;
   logic signed [TERM_W-1:0] term_ff, term_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [ACC_W-17:0] q_val;
   logic [VALUE_W-1:0]       sat_val;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_data_ff;
   logic                 rsp_user_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // corner bits: axis a is the most significant bit of the corner number
   assign corner_bit = {cnt_ff[0], cnt_ff[1], cnt_ff[2], cnt_ff[3]};

   always_comb begin
      lo = '0;
      for (int k = 0; k < AXES; k++) begin
         lo         = job_ff.idx[k];
         sel_idx[k] = lo;
         sel_wt[k]  = WT_ONE - job_ff.wt[k];
         if (corner_bit[k]) begin
            sel_idx[k] = (lo == IDX_W'(BINS - 1)) ? lo : lo + IDX_W'(1);
            sel_wt[k]  = job_ff.wt[k];
         end
      end
      rd_addr = ((TAB_AW'(sel_idx[0]) * TAB_AW'(BINS) + TAB_AW'(sel_idx[1]))
                * TAB_AW'(BINS) + TAB_AW'(sel_idx[2])) * TAB_AW'(BINS)
                + TAB_AW'(sel_idx[3]);
   end

   // products of Q0.16 weights, each rounded back to Q0.16; the table value times the weight is kept whole
   always_comb begin
      p_ab    = 34'(sel_wt[0]) * 34'(sel_wt[1]) + 34'd32768;
      p_abc   = 34'(wab_ff) * 34'(wc1_ff) + 34'd32768;
      p_w     = 34'(wabc_ff) * 34'(wd2_ff) + 34'd32768;
      term_in = $signed({{(TERM_W-VALUE_W){data3_ff[VALUE_W-1]}}, data3_ff})
              * $signed({{(TERM_W-WT_W){1'b0}}, w_ff});
   end

   // round half up, floor shift, saturate
   always_comb begin
      rnd     = acc_ff + ACC_W'(32768);
      q_val   = rnd[ACC_W-1:16];
      sat_val = q_val[VALUE_W-1:0];
      if (q_val > Q_HI) begin
         sat_val = 32'h7FFF_FFFF;
      end else if (q_val < Q_LO) begin
         sat_val = 32'h8000_0000;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      q_pop     = 1'b0;
      job_ld    = 1'b0;
      acc_clr   = 1'b0;
      mem_we    = 1'b0;
      issue     = 1'b0;
      load_out  = 1'b0;
      out_value = '0;
      out_cmd   = CMD_WRITE;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (q_job.cmd == CMD_QUERY) begin
                  q_pop    = 1'b1;
                  job_ld   = 1'b1;
                  acc_clr  = 1'b1;
                  cnt_in   = '0;
                  state_in = BK_RUN;
               end else if (out_free) begin
                  q_pop    = 1'b1;
                  mem_we   = q_job.wr_ok;
                  load_out = 1'b1;
               end
            end
         end
         BK_RUN: begin
            issue  = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == LAST_CORNER) begin
               state_in = BK_WAIT;
            end
         end
         BK_WAIT: begin
            if (v4_ff && last4_ff) begin
               state_in = BK_FIN;
            end
         end
         BK_FIN: begin
            if (out_free) begin
               load_out  = 1'b1;
               out_value = sat_val;
               out_cmd   = CMD_QUERY;
               state_in  = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[q_job.addr] <= q_job.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (job_ld) begin
         job_ff <= q_job;
      end
      if (load_out) begin
         rsp_data_ff <= out_value;
         rsp_user_ff <= out_cmd;
      end
      last1_ff <= (cnt_ff == LAST_CORNER);
      wab_ff   <= p_ab[32:16];
      wc1_ff   <= sel_wt[2];
      wd1_ff   <= sel_wt[3];
      last2_ff <= last1_ff;
      data2_ff <= rd_data_ff;
      wabc_ff  <= p_abc[32:16];
      wd2_ff   <= wd1_ff;
      last3_ff <= last2_ff;
      data3_ff <= data2_ff;
      w_ff     <= p_w[32:16];
      last4_ff <= last3_ff;
      term_ff  <= term_in;
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (v4_ff) begin
         acc_ff <= acc_ff + ACC_W'(term_ff);
      end
   end

endmodule

`default_nettype wire

### sv/quadrilinear_table_interpolator.sv
// top level of the four-dimensional table interpolator
//
//   channel   dir  handshake               payload
//   req_      in   req_tvalid/req_tready   req_tdata, req_tuser (command)
//   rsp_      out  rsp_tvalid/rsp_tready   rsp_tdata, rsp_tuser (command_done)
//   csr_      in   csr_valid/csr_ready     csr_index, csr_data
//
// a query holds the front end through accept, a multiply and a map step per axis on the shared
// 33x32 multiplier, and push, and the back end through pop, 16 table reads at one per cycle,
// the drain of the weight and accumulate pipeline and the round; the single read port sets the rate
// a write passes the front end through accept and push and the back end at its pop; the two-entry queue
// lets the next query be mapped during the corner walk; a stalled result waits in its register
// reset clears control state and the origin and scale registers only; the table is undefined until written
`timescale 1ns / 1ps
`default_nettype none

module quadrilinear_table_interpolator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // coord_a, coord_b, coord_c, coord_d, entry_address, entry_value, zero pad
   input  wire logic [qti_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // result_value
   output logic [qti_pkg::VALUE_W-1:0]          rsp_tdata,
   // command_done
   output logic                                 rsp_tuser,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [qti_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [qti_pkg::VALUE_W-1:0]     csr_data
);
   import qti_pkg::*;

   logic        push, q_full, q_valid, q_pop;
   qti_job_type push_job, q_job;

   qti_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push),
      .push_job   (push_job),
      .q_full     (q_full)
   );

   qti_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_job   (q_job),
      .pop       (q_pop)
   );

   qti_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### sv/qti_checker.sv
// port-level checks for the table interpolator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module qti_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic                            req_tuser,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [qti_pkg::VALUE_W-1:0]     rsp_tdata,
   input  wire logic                            rsp_tuser
);
   import qti_pkg::*;

   // nothing is presented in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented right after reset");

   // a write answers with a zero value
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CMD_WRITE) |-> rsp_tdata == '0)
      else $error("write transaction answered with nonzero value");

   // a query keeps the front end busy for its coordinate mapping
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_QUERY) |=> !req_tready ##1 !req_tready)
      else $error("request taken while a query is being mapped");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind quadrilinear_table_interpolator qti_checker u_qti_checker (.*);

`default_nettype wire

### test/tb_quadrilinear_table_interpolator.sv
// testbench of the quadrilinear table interpolator: table writes and interpolated queries
`timescale 1ns / 1ps

module tb_quadrilinear_table_interpolator;
   import qti_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam logic [VALUE_W-1:0] Q_MAX = 32'h7fff_ffff;
   localparam logic [VALUE_W-1:0] Q_MIN = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] Q_ONE = 32'h0001_0000;

   typedef logic [AXES-1:0][COORD_W-1:0] point_t;

   typedef struct packed {
      logic [AXES-1:0][1:0][IDX_W-1:0] idx;
      logic [AXES-1:0][1:0][WT_W-1:0]  wt;
   } span_t;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               done;
   } answer_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [VALUE_W-1:0]    rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [VALUE_W-1:0]    csr_data   = '0;

   // mirror of the table and of the axis registers
   bit [VALUE_W-1:0] grid_mirror [TABLE_DEPTH];
   bit               grid_written [TABLE_DEPTH];
   logic [31:0]      origin_mirror [AXES];
   logic [31:0]      scale_mirror [AXES];
   int               window_base [AXES];

   answer_t            pending_answers [$];
   answer_t            checked_due;
   bit                 stall_on = 1'b1;
   bit                 fill_forced = 1'b0;
   logic [VALUE_W-1:0] fill_level = '0;
   int items_sent, writes_sent, queries_sent, saturated_queries, settings_loaded;
   int answers_checked, error_count, quiet_cycles;

   quadrilinear_table_interpolator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // lower index and weights on every axis for one point
   function automatic span_t locate(input point_t p);
      span_t            s;
      longint           diff;
      logic [63:0]      mag, prod, t;
      logic [IDX_W-1:0] lo;
      logic [WT_W-1:0]  w;
      for (int ax = 0; ax < AXES; ax++) begin
         diff = longint'($signed(p[ax])) - longint'($signed(origin_mirror[ax]));
         mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
         prod = mag * {32'd0, scale_mirror[ax]};
         if (diff < 0 && prod > 64'h8000_0000) begin
            // below range
            lo = '0;
            w  = '0;
         end else begin
            t = (diff < 0) ? 64'h8000_0000 - prod : prod + 64'h8000_0000;
            if (t[63:32] > 32'(BINS - 1)) begin
               // above range
               lo = IDX_W'(BINS - 1);
               w  = WT_ONE;
            end else begin
               lo = t[32 +: IDX_W];
               w  = {1'b0, t[31:16]};
            end
         end
         s.idx[ax][0] = lo;
         s.idx[ax][1] = (lo == IDX_W'(BINS - 1)) ? lo : lo + 1'b1;
         s.wt[ax][0]  = WT_ONE - w;
         s.wt[ax][1]  = w;
      end
      return s;
   endfunction

   // corner bits: a in bit 3 down to d in bit 0
   function automatic logic [ADDR_W-1:0] corner_addr(input span_t s, input int k);
      return {s.idx[0][k[3]], s.idx[1][k[2]], s.idx[2][k[1]], s.idx[3][k[0]]};
   endfunction

   function automatic longint unsigned wround(input longint unsigned x, input longint unsigned y);
      return (x * y + 64'd32768) >> 16;
   endfunction

   function automatic answer_t interpolate(input point_t p);
      span_t           s;
      longint          acc, q;
      longint unsigned w;
      answer_t         r;
      s   = locate(p);
      acc = 0;
      for (int k = 0; k < CORNERS; k++) begin
         w = wround(wround(wround(s.wt[0][k[3]], s.wt[1][k[2]]), s.wt[2][k[1]]), s.wt[3][k[0]]);
         acc += longint'($signed(grid_mirror[corner_addr(s, k)])) * longint'(w);
      end
      q = (acc + 64'sd32768) >>> 16;
      r.done = CMD_QUERY;
      if (q > 64'sd2147483647) begin
         r.value = Q_MAX;
         saturated_queries++;
      end else if (q < -64'sd2147483648) begin
         r.value = Q_MIN;
         saturated_queries++;
      end else begin
         r.value = q[31:0];
      end
      return r;
   endfunction

   function automatic point_t noise_point();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [VALUE_W-1:0] fill_value();
      if (fill_forced)
         return fill_level;
      case ($urandom_range(0, 9))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return 32'(int'($urandom_range(0, 262143)) - 131072);
         default: return $urandom;
      endcase
   endfunction

   // coordinate that lands at a random fraction inside the given bin of one axis
   function automatic logic [COORD_W-1:0] aim_coord(input int ax, input int bin);
      longint target;
      longint offs;
      if (scale_mirror[ax] == '0)
         return $urandom;
      target = (longint'(bin) <<< 32) + longint'({32'd0, $urandom}) - 64'sd2147483648;
      offs   = target / longint'({32'd0, scale_mirror[ax]});
      return origin_mirror[ax] + offs[31:0];
   endfunction

   function automatic point_t pick_point();
      point_t p;
      int     r;
      for (int ax = 0; ax < AXES; ax++) begin
         r = $urandom_range(0, 99);
         if (r < 72)
            p[ax] = aim_coord(ax, window_base[ax] + int'($urandom_range(0, 1)));
         else if (r < 82)
            p[ax] = aim_coord(ax, -1 - int'($urandom_range(0, 2)));
         else if (r < 92)
            p[ax] = aim_coord(ax, BINS - 1 + int'($urandom_range(0, 3)));
         else if (r < 95)
            p[ax] = aim_coord(ax, int'($urandom_range(0, BINS - 1)));
         else if (r < 97)
            p[ax] = $urandom;
         else
            p[ax] = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      end
      return p;
   endfunction

   function automatic void new_windows();
      for (int ax = 0; ax < AXES; ax++)
         window_base[ax] = $urandom_range(0, BINS - 2);
   endfunction

   task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                            input logic [VALUE_W-1:0] value, input point_t p);
      answer_t due;
      if (stall_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'({value, addr, p});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (cmd == CMD_WRITE) begin
         grid_mirror[addr]  = value;
         grid_written[addr] = 1'b1;
         writes_sent++;
         due.value = '0;
         due.done  = CMD_WRITE;
      end else begin
         due = interpolate(p);
         queries_sent++;
      end
      pending_answers.push_back(due);
   endtask

   // every corner that the query reads gets written first
   task automatic run_query(input point_t p);
      span_t             s;
      logic [ADDR_W-1:0] a;
      s = locate(p);
      for (int k = 0; k < CORNERS; k++) begin
         a = corner_addr(s, k);
         if (!grid_written[a])
            send_item(CMD_WRITE, a, fill_value(), noise_point());
      end
      send_item(CMD_QUERY, ADDR_W'($urandom), $urandom, p);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic program_axes(input point_t origins, input point_t scales);
      for (int r = 0; r < 2 * AXES; r++) begin
         csr_valid <= 1'b1;
         csr_index <= (r < AXES) ? CSR_IDX_W'(CSR_ORIGIN_A + r) : CSR_IDX_W'(CSR_SCALE_A + r - AXES);
         csr_data  <= (r < AXES) ? origins[r] : scales[r - AXES];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         if (r < AXES)
            origin_mirror[r] = origins[r];
         else
            scale_mirror[r - AXES] = scales[r - AXES];
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic random_traffic(input int count);
      int                              stop_at;
      int                              r;
      logic [AXES-1:0][IDX_W-1:0]      hot;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            run_query(pick_point());
         end else if (r < 85) begin
            send_item(CMD_WRITE, ADDR_W'($urandom), fill_value(), noise_point());
         end else begin
            // overwrite an entry near the hot region
            for (int ax = 0; ax < AXES; ax++) begin
               r = window_base[ax] + int'($urandom_range(0, 2));
               hot[ax] = IDX_W'((r > BINS - 1) ? BINS - 1 : r);
            end
            send_item(CMD_WRITE, {hot[0], hot[1], hot[2], hot[3]}, fill_value(), noise_point());
         end
      end
   endtask

   // reset register values, address and coordinate extremes, range edges
   task automatic test_directed();
      send_item(CMD_WRITE, '0, Q_MAX, noise_point());
      send_item(CMD_WRITE, '1, Q_MIN, noise_point());
      run_query({4{Q_MIN}});
      run_query({4{32'hffff_8000}});   // t exactly zero
      run_query({4{32'hffff_7fff}});   // just below range
      run_query('0);                   // halfway between bins 0 and 1
      run_query({4{Q_MAX}});
      run_query({4{32'h001e_8000}});   // t exactly 31, upper index clamps
      run_query({4{32'h001f_8000}});   // t exactly 32, above range
      run_query({32'h0000_0100, 32'hffff_9000, 32'h0000_6000, 32'h0000_4000});
   endtask

   task automatic test_config_sweep();
      point_t o, s;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               o = '0;
               s = {4{Q_ONE}};
            end
            1: begin
               for (int ax = 0; ax < AXES; ax++)
                  o[ax] = 32'(int'($urandom_range(0, 4194304)) - 2097152);
               s = {4{32'h0004_0000}};
            end
            2: begin
               o = {32'd0, $urandom, Q_MAX, Q_MIN};
               s = {$urandom, 32'h0000_8000, 32'hffff_ffff, 32'h0000_0000};
            end
            default: begin
               for (int ax = 0; ax < AXES; ax++) begin
                  o[ax] = $urandom;
                  s[ax] = $urandom_range(32'h0000_1000, 32'h0010_0000);
               end
            end
         endcase
         wait_drain();
         program_axes(o, s);
         new_windows();
         random_traffic(230);
      end
   endtask

   // a cluster full of one extreme value pushes the rounded weights past full scale
   task automatic test_saturation();
      point_t p;
      wait_drain();
      program_axes('0, {4{Q_ONE}});
      new_windows();
      fill_forced = 1'b1;
      for (int pass = 0; pass < 2; pass++) begin
         fill_level = pass ? Q_MIN : Q_MAX;
         for (int k = 0; k < CORNERS; k++)
            send_item(CMD_WRITE, {IDX_W'(window_base[0] + k[3]), IDX_W'(window_base[1] + k[2]),
                                  IDX_W'(window_base[2] + k[1]), IDX_W'(window_base[3] + k[0])},
                      fill_level, noise_point());
         repeat (16) begin
            for (int ax = 0; ax < AXES; ax++)
               p[ax] = aim_coord(ax, window_base[ax]);
            run_query(p);
         end
      end
      fill_forced = 1'b0;
   endtask

   task automatic test_drain_pause();
      new_windows();
      random_traffic(60);
      wait_drain();
      random_traffic(60);
   endtask

   task automatic test_full_rate();
      point_t o;
      wait_drain();
      stall_on = 1'b0;
      for (int ax = 0; ax < AXES; ax++)
         o[ax] = 32'(int'($urandom_range(0, 1048576)) - 524288);
      program_axes(o, {4{32'h0002_0000}});
      new_windows();
      random_traffic(250);
   endtask

   initial begin : rsp_ready_driver
      int gap;
      forever begin
         @(posedge clock);
         if (stall_on && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result transaction, expected none, actual value %h done %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            checked_due = pending_answers.pop_front();
            answers_checked++;
            if (rsp_tdata !== checked_due.value) begin
               error_count++;
               $display("%0t: result_value mismatch, expected %h, actual %h",
                        $time, checked_due.value, rsp_tdata);
            end
            if (rsp_tuser !== checked_due.done) begin
               error_count++;
               $display("%0t: command_done mismatch, expected %b, actual %b",
                        $time, checked_due.done, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                  $time, QUIET_LIMIT, pending_answers.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : run_tests
      for (int ax = 0; ax < AXES; ax++) begin
         origin_mirror[ax] = '0;
         scale_mirror[ax]  = Q_ONE;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_saturation();
      test_drain_pause();
      test_full_rate();
      wait_drain();
      repeat (40) @(posedge clock);
      $display("sent %0d items: %0d table writes and %0d queries, %0d queries saturated",
               items_sent, writes_sent, queries_sent, saturated_queries);
      $display("%0d results checked over %0d axis register settings, %0d mismatches",
               answers_checked, settings_loaded, error_count);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### quadrilinear_table_interpolator.f
sv/qti_pkg.sv
sv/qti_front.sv
sv/qti_queue.sv
sv/qti_back.sv
sv/quadrilinear_table_interpolator.sv
sv/qti_checker.sv
test/tb_quadrilinear_table_interpolator.sv
